>>> design/spfs_pkg.sv
// Package for the strict-priority FIFO scheduler.
// Holds the default sizes, field widths, command codes and result status codes.
// No dependencies.
package spfs_pkg;

    // Default sizes for the top-level parameters.
    localparam int QUEUE_DEPTH_DEFAULT = 8;
    localparam int LEVELS_DEFAULT      = 4;
    localparam int ID_WIDTH_DEFAULT    = 16;

    // Widths of the stream fields.
    localparam int JOB_ID_W    = 16;
    localparam int PRIORITY_W  = 2;
    localparam int CMD_W       = 1;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = 24;
    localparam int TDATA_PAD_W = TDATA_W - JOB_ID_W - PRIORITY_W;

    // Request kinds carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 1'b1;

    // Result status carried in m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

>>> design/spfs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the job id slots of all priority queues. No dependencies.
module spfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/strict_priority_fifo_scheduler_unit.sv
// Strict-priority scheduler: one FIFO of job ids per priority level.
// A request passes the middle stage and the result register before m_tvalid shows it.
// One request per cycle while m_tready allows; one RAM read port serves the dequeue.
// Reset (aresetn low, synchronous) empties all queues and clears the pipeline valids.
// The slot RAM itself is not cleared; occupancy guards every read.
// Depends on spfs_pkg and spfs_ram.
module strict_priority_fifo_scheduler_unit #(
    parameter int QUEUE_DEPTH = spfs_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int LEVELS      = spfs_pkg::LEVELS_DEFAULT,
    parameter int ID_WIDTH    = spfs_pkg::ID_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Request channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spfs_pkg::TDATA_W-1:0] s_tdata,   // [15:0] job_id, [17:16] priority_req
    input  logic [spfs_pkg::CMD_W-1:0]   s_tuser,   // [0] cmd
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spfs_pkg::TDATA_W-1:0] m_tdata,   // [15:0] out_job_id, [17:16] out_priority
    output logic [spfs_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOTS  = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    // Queue state.
    logic [PTR_W-1:0] rd_ptr_reg [LEVELS];
    logic [PTR_W-1:0] rd_ptr_next [LEVELS];
    logic [PTR_W-1:0] wr_ptr_reg [LEVELS];
    logic [PTR_W-1:0] wr_ptr_next [LEVELS];
    logic [CNT_W-1:0] occ_reg [LEVELS];
    logic [CNT_W-1:0] occ_next [LEVELS];

    // Stage between request and result.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    spfs_pkg::status_t   s1_status_reg;
    spfs_pkg::status_t   s1_status_next;
    logic [LVL_W-1:0]    s1_lvl_reg;
    logic [LVL_W-1:0]    s1_lvl_next;

    // Result register.
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [spfs_pkg::TDATA_W-1:0] m_data_reg;
    logic [spfs_pkg::TDATA_W-1:0] m_data_next;
    spfs_pkg::status_t            m_status_reg;
    spfs_pkg::status_t            m_status_next;

    // Request decode.
    logic                             accept;
    logic                             is_enq;
    logic                             is_deq;
    logic [spfs_pkg::CMD_W-1:0]       in_cmd;
    logic [spfs_pkg::JOB_ID_W-1:0]    in_job_id;
    logic [spfs_pkg::PRIORITY_W-1:0]  in_pri;
    logic                             s1_advance;

    // Per-level control.
    logic [LEVELS-1:0] push;
    logic [LEVELS-1:0] pop;
    logic              sel_found;
    logic [LVL_W-1:0]  sel_lvl;

    // RAM port signals.
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ID_WIDTH-1:0] ram_wdata;
    logic [ID_WIDTH-1:0] ram_rdata;
    logic [31:0]         id_in_ext;
    logic [31:0]         id_out_ext;
    logic [31:0]         lvl_ext;

    // Handshake: the middle stage moves on whenever the result register is free.
    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;

    assign in_cmd    = s_tuser;
    assign in_job_id = s_tdata[spfs_pkg::JOB_ID_W-1:0];
    assign in_pri    = s_tdata[spfs_pkg::JOB_ID_W +: spfs_pkg::PRIORITY_W];
    assign is_enq    = accept && (in_cmd == spfs_pkg::CMD_ENQUEUE);
    assign is_deq    = accept && (in_cmd == spfs_pkg::CMD_DEQUEUE);

    // Highest non-empty level; later levels override lower ones.
    always_comb begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (occ_reg[i] != '0) begin
                sel_found = 1'b1;
                sel_lvl   = LVL_W'(i);
            end
        end
    end

    // Per-level push, pop, pointer and count updates, plus RAM addresses.
    always_comb begin
        ram_waddr = '0;
        ram_raddr = '0;
        for (int i = 0; i < LEVELS; i++) begin
            push[i] = is_enq && (int'(in_pri) == i) && (occ_reg[i] != CNT_W'(QUEUE_DEPTH));
            pop[i]  = is_deq && sel_found && (sel_lvl == LVL_W'(i));

            if (push[i]) begin
                ram_waddr = ram_waddr | ADDR_W'(i * QUEUE_DEPTH + int'(wr_ptr_reg[i]));
            end
            if (pop[i]) begin
                ram_raddr = ram_raddr | ADDR_W'(i * QUEUE_DEPTH + int'(rd_ptr_reg[i]));
            end

            wr_ptr_next[i] = wr_ptr_reg[i];
            if (push[i]) begin
                wr_ptr_next[i] = (wr_ptr_reg[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : wr_ptr_reg[i] + 1'b1;
            end
            rd_ptr_next[i] = rd_ptr_reg[i];
            if (pop[i]) begin
                rd_ptr_next[i] = (rd_ptr_reg[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : rd_ptr_reg[i] + 1'b1;
            end

            occ_next[i] = occ_reg[i];
            if (push[i]) begin
                occ_next[i] = occ_reg[i] + 1'b1;
            end else if (pop[i]) begin
                occ_next[i] = occ_reg[i] - 1'b1;
            end
        end
    end

    assign ram_we    = |push;
    assign ram_re    = |pop;
    assign id_in_ext = 32'(in_job_id);
    assign ram_wdata = id_in_ext[ID_WIDTH-1:0];

    // Status and level for the middle stage.
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_status_next = s1_status_reg;
        s1_lvl_next    = s1_lvl_reg;
        if (s_tready) begin
            s1_valid_next = accept;
            s1_lvl_next   = sel_lvl;
            if (in_cmd == spfs_pkg::CMD_ENQUEUE) begin
                s1_status_next = (|push) ? spfs_pkg::ST_ENQUEUED : spfs_pkg::ST_FULL;
            end else begin
                s1_status_next = sel_found ? spfs_pkg::ST_DEQUEUED : spfs_pkg::ST_EMPTY;
            end
        end
    end

    // Result assembly; only a successful dequeue carries an id and a level.
    assign id_out_ext = 32'(ram_rdata);
    assign lvl_ext    = 32'(s1_lvl_reg);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (s1_advance) begin
            m_valid_next  = s1_valid_reg;
            m_status_next = s1_status_reg;
            if (s1_status_reg == spfs_pkg::ST_DEQUEUED) begin
                m_data_next = {{spfs_pkg::TDATA_PAD_W{1'b0}},
                               lvl_ext[spfs_pkg::PRIORITY_W-1:0],
                               id_out_ext[spfs_pkg::JOB_ID_W-1:0]};
            end else begin
                m_data_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                occ_reg[i]    <= '0;
            end
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            for (int i = 0; i < LEVELS; i++) begin
                rd_ptr_reg[i] <= rd_ptr_next[i];
                wr_ptr_reg[i] <= wr_ptr_next[i];
                occ_reg[i]    <= occ_next[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        s1_status_reg <= s1_status_next;
        s1_lvl_reg    <= s1_lvl_next;
        m_data_reg    <= m_data_next;
        m_status_reg  <= m_status_next;
    end

    // Job id slots of all levels, level-major.
    spfs_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

>>> design/spfs_checker.sv
// Port-level checker for the strict-priority scheduler, bound to the top level.
// Depends on spfs_pkg and strict_priority_fifo_scheduler_unit.
module spfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spfs_pkg::TDATA_W-1:0]  s_tdata,
    input logic [spfs_pkg::CMD_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spfs_pkg::TDATA_W-1:0]  m_tdata,
    input logic [spfs_pkg::STATUS_W-1:0] m_tuser
);

    // A stalled result transfer keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a dequeued job carries an id and a level.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != spfs_pkg::ST_DEQUEUED) |-> m_tdata == '0)
        else $error("non-dequeue result with nonzero payload");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A free result side never holds back requests.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("request stalled while result side is ready");

endmodule

bind strict_priority_fifo_scheduler_unit spfs_checker u_spfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/testbench.sv
// Self-checking testbench for strict_priority_fifo_scheduler_unit.
// Drives job requests through its own scheduling predictor and compares every result.
// Depends on spfs_pkg and the scheduler RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = spfs_pkg::QUEUE_DEPTH_DEFAULT;
    localparam int LEVELS          = spfs_pkg::LEVELS_DEFAULT;
    localparam int JOB_ID_W        = spfs_pkg::JOB_ID_W;
    localparam int PRIORITY_W      = spfs_pkg::PRIORITY_W;
    localparam int CMD_W           = spfs_pkg::CMD_W;
    localparam int STATUS_W        = spfs_pkg::STATUS_W;
    localparam int TDATA_W         = spfs_pkg::TDATA_W;
    localparam int TDATA_PAD_W     = spfs_pkg::TDATA_PAD_W;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int RANDOM_ROUNDS   = 7;
    localparam int ROUND_ITEMS     = 250;

    typedef enum {READY_ALWAYS, READY_LIGHT, READY_HEAVY, READY_PATTERN} ready_mode_t;

    // One expected scheduler result.
    typedef struct {
        spfs_pkg::status_t     status;
        logic [JOB_ID_W-1:0]   job_id;
        logic [PRIORITY_W-1:0] level;
    } sched_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Predictor copy of the per-level job queues.
    logic [JOB_ID_W-1:0]   slot_mem [LEVELS][DEPTH];
    int                    head_idx [LEVELS];
    int                    tail_idx [LEVELS];
    int                    fill_count [LEVELS];

    sched_result_t         pending_results [$];
    int                    error_count = 0;
    int                    sent_count = 0;
    int                    checked_count = 0;
    int                    outcome_count [4] = '{0, 0, 0, 0};
    int                    cycle_count = 0;

    // Sender pacing and receiver behavior controls.
    bit                    bursty_sender = 1'b1;
    int                    burst_left = 1;
    ready_mode_t           ready_mode = READY_ALWAYS;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    int                    hold_left = 0;
    int                    pattern_phase = 0;

    strict_priority_fifo_scheduler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Compute the result of one accepted request and update the queue copy.
    function automatic sched_result_t schedule_request(input logic [CMD_W-1:0] cmd,
                                                       input logic [JOB_ID_W-1:0] id,
                                                       input logic [PRIORITY_W-1:0] pri);
        sched_result_t r;
        int lvl;
        r.status = spfs_pkg::ST_ENQUEUED;
        r.job_id = '0;
        r.level  = '0;
        if (cmd == spfs_pkg::CMD_ENQUEUE) begin
            if (int'(pri) >= LEVELS || fill_count[pri] >= DEPTH) begin
                r.status = spfs_pkg::ST_FULL;
            end else begin
                slot_mem[pri][tail_idx[pri]] = id;
                tail_idx[pri] = (tail_idx[pri] + 1) % DEPTH;
                fill_count[pri]++;
            end
        end else begin
            r.status = spfs_pkg::ST_EMPTY;
            // The highest non-empty level gives up its oldest job.
            for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
                if (r.status == spfs_pkg::ST_EMPTY && fill_count[lvl] != 0) begin
                    r.status = spfs_pkg::ST_DEQUEUED;
                    r.job_id = slot_mem[lvl][head_idx[lvl]];
                    r.level  = PRIORITY_W'(lvl);
                    head_idx[lvl] = (head_idx[lvl] + 1) % DEPTH;
                    fill_count[lvl]--;
                end
            end
        end
        return r;
    endfunction

    // Insert a random gap once the current burst is used up.
    task automatic pace_sender();
        int gap;
        if (bursty_sender) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                s_tdata  <= TDATA_W'($urandom);
                s_tuser  <= CMD_W'($urandom);
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Offer one request, wait for its transfer and record the expected result.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [JOB_ID_W-1:0] id,
                                input logic [PRIORITY_W-1:0] pri);
        s_tvalid <= 1'b1;
        s_tdata  <= {{TDATA_PAD_W{1'b0}}, pri, id};
        s_tuser  <= cmd;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_results.push_back(schedule_request(cmd, id, pri));
        sent_count++;
        pace_sender();
    endtask

    // Random request, optionally concentrated on one priority level.
    task automatic send_random_request(input int enq_pct, input int focus_level,
                                       input int focus_pct);
        logic [CMD_W-1:0]      cmd;
        logic [PRIORITY_W-1:0] pri;
        cmd = ($urandom_range(99) < enq_pct) ? spfs_pkg::CMD_ENQUEUE : spfs_pkg::CMD_DEQUEUE;
        pri = ($urandom_range(99) < focus_pct) ? focus_level[PRIORITY_W-1:0]
                                               : PRIORITY_W'($urandom);
        send_request(cmd, JOB_ID_W'($urandom), pri);
    endtask

    // Receiver: a long hold-off when requested, otherwise the selected stall pattern.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            pattern_phase <= (pattern_phase + 1) % 8;
            case (ready_mode)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_LIGHT:   m_tready <= ($urandom_range(3) != 0);
                READY_HEAVY:   m_tready <= ($urandom_range(3) == 0);
                READY_PATTERN: m_tready <= (pattern_phase < 5);
                default:       m_tready <= 1'b1;
            endcase
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, status 0x%0h data 0x%0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                outcome_count[want.status]++;
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("out_job_id", 32'(want.job_id), 32'(m_tdata[JOB_ID_W-1:0]));
                check_field("out_priority", 32'(want.level),
                            32'(m_tdata[JOB_ID_W +: PRIORITY_W]));
                check_field("tdata padding", 32'(0),
                            32'(m_tdata[TDATA_W-1:JOB_ID_W+PRIORITY_W]));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Empty dequeue, one job per level, then dequeues that must come out highest first.
    // The id and priority fields of a dequeue carry junk to show they are ignored.
    task automatic test_priority_order();
        int i;
        ready_mode = READY_ALWAYS;
        send_request(spfs_pkg::CMD_DEQUEUE, 16'hFFFF, 2'd3);
        send_request(spfs_pkg::CMD_ENQUEUE, 16'h0000, 2'd0);
        send_request(spfs_pkg::CMD_ENQUEUE, 16'hFFFF, 2'd3);
        send_request(spfs_pkg::CMD_ENQUEUE, 16'hA5A5, 2'd1);
        send_request(spfs_pkg::CMD_ENQUEUE, 16'h5A5A, 2'd2);
        for (i = 0; i < 5; i++)
            send_request(spfs_pkg::CMD_DEQUEUE, JOB_ID_W'($urandom), PRIORITY_W'($urandom));
    endtask

    // Fill one level to its depth; the next enqueue must be dropped as full.
    task automatic test_full_queue();
        int i;
        ready_mode = READY_LIGHT;
        for (i = 0; i <= DEPTH; i++)
            send_request(spfs_pkg::CMD_ENQUEUE, JOB_ID_W'(16'h1000 + i), 2'd1);
        send_request(spfs_pkg::CMD_DEQUEUE, 16'hFFFF, 2'd3);
        send_request(spfs_pkg::CMD_DEQUEUE, 16'h0000, 2'd0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering requests.
    task automatic test_back_pressure();
        int i;
        bursty_sender = 1'b0;
        hold_requests++;
        for (i = 0; i < 40; i++)
            send_random_request(60, 0, 0);
        bursty_sender = 1'b1;
    endtask

    // Rounds that alternate between filling and draining the queues.
    task automatic test_random_traffic();
        int enqueue_pct [RANDOM_ROUNDS] = '{85, 50, 15, 65, 35, 90, 10};
        int r;
        int i;
        int focus;
        for (r = 0; r < RANDOM_ROUNDS; r++) begin
            ready_mode    = ready_mode_t'(r % 4);
            bursty_sender = (r % 3 != 2);
            focus         = $urandom_range(LEVELS - 1);
            for (i = 0; i < ROUND_ITEMS; i++)
                send_random_request(enqueue_pct[r], focus, (r % 2 == 1) ? 50 : 0);
        end
    endtask

    initial begin
        int lvl;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = spfs_pkg::CMD_ENQUEUE;
        aresetn  = 1'b0;
        for (lvl = 0; lvl < LEVELS; lvl++) begin
            head_idx[lvl]   = 0;
            tail_idx[lvl]   = 0;
            fill_count[lvl] = 0;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_priority_order();
        test_full_queue();
        test_back_pressure();
        test_random_traffic();

        // Let the block drain everything that is still expected.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests and %0d results, including a %0d-cycle receiver hold-off.",
                 sent_count, checked_count, HOLD_OFF_CYCLES);
        $display("Outcomes: %0d enqueued, %0d dequeued, %0d empty, %0d dropped as full.",
                 outcome_count[spfs_pkg::ST_ENQUEUED], outcome_count[spfs_pkg::ST_DEQUEUED],
                 outcome_count[spfs_pkg::ST_EMPTY], outcome_count[spfs_pkg::ST_FULL]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> strict_priority_fifo_scheduler_unit.f
design/spfs_pkg.sv
design/spfs_ram.sv
design/strict_priority_fifo_scheduler_unit.sv
design/spfs_checker.sv
verif/testbench.sv
